// ===== src/cpwm_pkg.sv =====
// Shared constants and codes for the center-aligned PWM scheduler.
`timescale 1ns / 1ps

package cpwm_pkg;

	// Default build parameters.
	localparam int CHANNELS_DEFAULT      = 8;
	localparam int ACT_FRAC_BITS_DEFAULT = 16;

	// Field widths of one input beat and one result beat.
	localparam int CHANNEL_W    = 3;
	localparam int ACTIVATION_W = 18;
	localparam int TIME_W       = 32;
	localparam int TICKS_W      = 16;
	localparam int COMMANDS_W   = 8;
	localparam int WINDOW_W     = 34;
	localparam int S_TDATA_W    = 56;

	// Register file: index width and register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_PULSE_TICKS = 1'b1;

	// Register reset values.
	localparam logic [TICKS_W-1:0] PERIOD_TICKS_RESET    = 16'd1000;
	localparam logic [TICKS_W-1:0] MIN_PULSE_TICKS_RESET = 16'd0;

	// Item kinds carried on tuser.
	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

endpackage

// ===== src/centered_pwm_scheduler_deadband_top.sv =====
// Top level of the center-aligned PWM scheduler with minimum-pulse deadband.
`timescale 1ns / 1ps

// Usage:
// Input beats arrive on the s_ stream. tuser selects the kind: a load beat sets
// one channel's window from a signed activation (full on = 1 << ACT_FRAC_BITS)
// and a frame start time; a query beat carries a tick time and returns one
// result beat on the m_ stream holding the on/off mask of the first eight
// channels. Load beats give no result.
// A query result is presented on the m_ stream from the result register: the
// beat is captured in the input register, and the result register loads from it
// once the result slot is free. Throughput is one beat per cycle while the
// receiver does not stall; the single input register stage with the multiplier
// and window adders sets this figure. A query right after a load sees that load.
// Configuration (period and minimum pulse) is written through cfg_we, cfg_index and
// cfg_wdata while the block is idle; the user must ensure this, the block does not enforce it.
// Reset clears all channel active flags, loads the register reset values and
// empties both the input and the result register.
// When the receiver stalls, the result is held in the result register and
// the input side keeps taking load beats and one further query beat before
// s_tready drops.
module centered_pwm_scheduler_deadband_top #(
	parameter int CHANNELS      = cpwm_pkg::CHANNELS_DEFAULT,
	parameter int ACT_FRAC_BITS = cpwm_pkg::ACT_FRAC_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [cpwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cpwm_pkg::TICKS_W-1:0]      cfg_wdata,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata from bit 0: channel[2:0], activation[20:3], time_ticks[52:21], zero pad.
	input  logic [cpwm_pkg::S_TDATA_W-1:0]    s_tdata,
	// tuser: mode[0].
	input  logic [0:0]                        s_tuser,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata from bit 0: commands[7:0].
	output logic [cpwm_pkg::COMMANDS_W-1:0]   m_tdata
);

	import cpwm_pkg::*;

	// Clamp operand width: wide enough for the full-scale value and the
	// largest positive activation.
	localparam int CW = (ACT_FRAC_BITS + 1 > ACTIVATION_W - 1) ?
		ACT_FRAC_BITS + 1 : ACTIVATION_W - 1;
	localparam logic [CW-1:0] FULL_SCALE = CW'(1) << ACT_FRAC_BITS;
	// Product width so that the on-time part-select always stays in range.
	localparam int PW = ACT_FRAC_BITS + TICKS_W + 1;
	localparam int OUT_CH = (CHANNELS < COMMANDS_W) ? CHANNELS : COMMANDS_W;

	// Configuration registers.
	logic [TICKS_W-1:0] period_ticks_q;
	logic [TICKS_W-1:0] min_pulse_ticks_q;

	// Input register stage.
	logic                     valid_s1;
	mode_t                    mode_s1;
	logic [CHANNEL_W-1:0]     channel_s1;
	logic [ACTIVATION_W-1:0]  activation_s1;
	logic [TIME_W-1:0]        time_ticks_s1;

	// Channel window state.
	logic [WINDOW_W-1:0] window_start_twice_q [CHANNELS];
	logic [WINDOW_W-1:0] window_end_twice_q   [CHANNELS];
	logic [CHANNELS-1:0] channel_active_q;

	// Result register.
	logic                  out_valid_q;
	logic [COMMANDS_W-1:0] commands_q;

	logic                  advance_s1;
	logic                  in_accept;
	logic [CW-1:0]         act_mag;
	logic [ACTIVATION_W-2:0] act_clamp;
	logic [PW-1:0]         product;
	logic [TICKS_W-1:0]    on_raw;
	logic                  on_zero;
	logic [WINDOW_W-1:0]   base_twice;
	logic [WINDOW_W-1:0]   new_start;
	logic [WINDOW_W-1:0]   new_end;
	logic [WINDOW_W-1:0]   query_twice;
	logic [CHANNELS-1:0]   hit;
	logic [COMMANDS_W-1:0] commands_d;

	// Handshake: a load always leaves stage 1; a query needs a free result slot.
	assign advance_s1 = valid_s1 &&
		(mode_s1 == MODE_LOAD || !out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;
	assign in_accept  = s_tvalid && s_tready;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = commands_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ticks_q    <= PERIOD_TICKS_RESET;
			min_pulse_ticks_q <= MIN_PULSE_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD_TICKS:    period_ticks_q    <= cfg_wdata;
				REG_MIN_PULSE_TICKS: min_pulse_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1       <= mode_t'(s_tuser[0]);
			channel_s1    <= s_tdata[CHANNEL_W-1:0];
			activation_s1 <= s_tdata[CHANNEL_W +: ACTIVATION_W];
			time_ticks_s1 <= s_tdata[CHANNEL_W + ACTIVATION_W +: TIME_W];
		end
	end

	// Clamp the activation to 0..full scale.
	always_comb begin
		act_mag = CW'(activation_s1[ACTIVATION_W-2:0]);
		if (activation_s1[ACTIVATION_W-1]) begin
			act_clamp = '0;
		end else if (act_mag > FULL_SCALE) begin
			act_clamp = FULL_SCALE[ACTIVATION_W-2:0];
		end else begin
			act_clamp = activation_s1[ACTIVATION_W-2:0];
		end
	end

	// On-time in whole ticks, then the strict minimum-pulse deadband.
	assign product = PW'(act_clamp) * PW'(period_ticks_q);
	assign on_raw  = product[ACT_FRAC_BITS +: TICKS_W];
	assign on_zero = (on_raw == '0) || (on_raw < min_pulse_ticks_q);

	// Window edges at twice their tick value, centered in the frame.
	assign base_twice = WINDOW_W'({time_ticks_s1, 1'b0}) + WINDOW_W'(period_ticks_q);
	assign new_start  = base_twice - WINDOW_W'(on_raw);
	assign new_end    = base_twice + WINDOW_W'(on_raw);

	// Per-channel window storage and window compare.
	assign query_twice = WINDOW_W'({time_ticks_s1, 1'b0});

	for (genvar i = 0; i < CHANNELS; i++) begin : g_channel
		logic load_hit;

		assign load_hit = advance_s1 && mode_s1 == MODE_LOAD &&
			int'(channel_s1) == i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				channel_active_q[i] <= 1'b0;
			end else if (load_hit) begin
				channel_active_q[i] <= !on_zero;
			end
		end

		always_ff @(posedge clk) begin
			if (load_hit && !on_zero) begin
				window_start_twice_q[i] <= new_start;
				window_end_twice_q[i]   <= new_end;
			end
		end

		assign hit[i] = channel_active_q[i] &&
			query_twice >= window_start_twice_q[i] &&
			query_twice <  window_end_twice_q[i];
	end

	// Map the first channels onto the command mask.
	for (genvar b = 0; b < COMMANDS_W; b++) begin : g_cmd
		if (b < OUT_CH) begin : g_used
			assign commands_d[b] = hit[b];
		end else begin : g_unused
			assign commands_d[b] = 1'b0;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && mode_s1 == MODE_QUERY) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance_s1 && mode_s1 == MODE_QUERY) begin
			commands_q <= commands_d;
		end
	end

endmodule

// ===== bench/tb_centered_pwm_scheduler_deadband_top.sv =====
// Self-checking testbench for the center-aligned PWM scheduler: directed table, then random phases.
`timescale 1ns / 1ps

module tb_centered_pwm_scheduler_deadband_top;
	import cpwm_pkg::*;

	localparam int NUM_CH         = CHANNELS_DEFAULT;
	localparam int FRAC           = ACT_FRAC_BITS_DEFAULT;
	localparam longint DUTY_FULL  = longint'(1) << FRAC;
	localparam int IDLE_PCT       = 29;
	localparam int SETTLE_CYCLES  = 4;
	localparam int STALL_LIMIT    = 2000;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_BEATS    = 190;
	localparam int STEADY_PHASE   = 3;

	// Activation codes used by the directed table (18-bit two's complement).
	localparam logic [ACTIVATION_W-1:0] ACT_FULL     = 18'h10000;
	localparam logic [ACTIVATION_W-1:0] ACT_HALF     = 18'h08000;
	localparam logic [ACTIVATION_W-1:0] ACT_MOST_NEG = 18'h20000;
	localparam logic [ACTIVATION_W-1:0] ACT_MOST_POS = 18'h1FFFF;
	localparam logic [ACTIVATION_W-1:0] ACT_LSB      = 18'h00001;
	localparam logic [ACTIVATION_W-1:0] ACT_SIXTY    = 18'h0999A;
	localparam logic [TIME_W-1:0]       T_MAX        = 32'hFFFF_FFFF;

	// One row of the directed script: a config change or a beat, with an optional typed result.
	typedef struct packed {
		logic                    is_cfg;
		mode_t                   mode;
		logic [CHANNEL_W-1:0]    ch;
		logic [ACTIVATION_W-1:0] act;
		logic [TIME_W-1:0]       t;
		logic                    known;
		logic [COMMANDS_W-1:0]   mask;
		logic [TICKS_W-1:0]      period;
		logic [TICKS_W-1:0]      min_pulse;
	} script_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [TICKS_W-1:0]     cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic [0:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [COMMANDS_W-1:0]  m_tdata;

	// Set for one phase so that neither side inserts gaps.
	logic steady;

	// Expected command masks, oldest first.
	logic [COMMANDS_W-1:0] commands_due [$];
	int                    fail_count  = 0;
	int                    idle_cycles = 0;

	// Shadow of the scheduler: timing registers and doubled window edges per channel.
	logic [TICKS_W-1:0]  period_reg;
	logic [TICKS_W-1:0]  min_pulse_reg;
	logic [WINDOW_W-1:0] win_lo2 [NUM_CH];
	logic [WINDOW_W-1:0] win_hi2 [NUM_CH];
	logic                ch_on   [NUM_CH];

	script_row_t script [26];

	centered_pwm_scheduler_deadband_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one beat to the shadow; returns 1 with the on-mask when the beat is a query.
	function automatic logic predict_commands(input mode_t mode, input logic [CHANNEL_W-1:0] ch,
			input logic [ACTIVATION_W-1:0] act, input logic [TIME_W-1:0] t,
			output logic [COMMANDS_W-1:0] mask);
		longint duty;
		longint on_ticks;
		longint twice_t;
		int i;
		twice_t = 2 * longint'(t);
		mask = '0;
		if (mode == MODE_LOAD) begin
			duty = longint'($signed(act));
			if (duty < 0)
				duty = 0;
			if (duty > DUTY_FULL)
				duty = DUTY_FULL;
			on_ticks = (duty * longint'(period_reg)) >>> FRAC;
			// Strict deadband: short nonzero pulses are dropped entirely.
			if (on_ticks != 0 && on_ticks < longint'(min_pulse_reg))
				on_ticks = 0;
			if (on_ticks == 0) begin
				ch_on[ch] = 1'b0;
			end else begin
				win_lo2[ch] = WINDOW_W'(twice_t + longint'(period_reg) - on_ticks);
				win_hi2[ch] = WINDOW_W'(twice_t + longint'(period_reg) + on_ticks);
				ch_on[ch]   = 1'b1;
			end
			return 1'b0;
		end
		for (i = 0; i < NUM_CH && i < COMMANDS_W; i++) begin
			mask[i] = ch_on[i] && twice_t >= longint'(win_lo2[i])
				&& twice_t < longint'(win_hi2[i]);
		end
		return 1'b1;
	endfunction

	// Random activation: mostly in range, with negatives, overdrive, raw bits and deadband edges.
	function automatic logic [ACTIVATION_W-1:0] pick_activation();
		longint edge_act;
		case ($urandom_range(0, 9))
			0: begin
				return {1'b1, 17'($urandom)};
			end
			1: begin
				return ACT_FULL;
			end
			2: begin
				return ACT_FULL + 18'($urandom_range(1, 65535));
			end
			3: begin
				return 18'($urandom);
			end
			4: begin
				if (period_reg == 0)
					return 18'($urandom_range(0, 65536));
				edge_act = (longint'(min_pulse_reg) * DUTY_FULL) / longint'(period_reg)
					+ longint'($urandom_range(0, 4)) - 2;
				if (edge_act < 0)
					edge_act = 0;
				if (edge_act > DUTY_FULL)
					edge_act = DUTY_FULL;
				return 18'(edge_act);
			end
			5: begin
				return 18'($urandom_range(0, 255));
			end
			default: begin
				return 18'($urandom_range(0, 65536));
			end
		endcase
	endfunction

	// Offers one beat with random gaps, waits for the handshake, then records its expected result.
	task automatic play_beat(input mode_t mode, input logic [CHANNEL_W-1:0] ch,
			input logic [ACTIVATION_W-1:0] act, input logic [TIME_W-1:0] t,
			input logic typed, input logic [COMMANDS_W-1:0] typed_mask);
		logic [COMMANDS_W-1:0] mask;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'b000, t, act, ch};
		do @(posedge clk); while (!s_tready);
		if (predict_commands(mode, ch, act, t, mask))
			commands_due.push_back(typed ? typed_mask : mask);
	endtask

	// Holds the sender off until every expected result is in and the pipeline has emptied.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (commands_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both timing registers back to back.
	task automatic set_timing(input logic [TICKS_W-1:0] period, input logic [TICKS_W-1:0] min_pulse);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PERIOD_TICKS;
		cfg_wdata <= period;
		@(posedge clk);
		cfg_index <= REG_MIN_PULSE_TICKS;
		cfg_wdata <= min_pulse;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_reg    = period;
		min_pulse_reg = min_pulse;
		@(posedge clk);
	endtask

	// Result side: check every accepted beat and stall at random outside the steady phase.
	always @(posedge clk) begin
		logic [COMMANDS_W-1:0] want;
		if (m_tvalid && m_tready) begin
			if (commands_due.size() == 0) begin
				$error("commands: no result expected, got %02h", m_tdata);
				fail_count++;
			end else begin
				want = commands_due.pop_front();
				if (m_tdata !== want) begin
					$error("commands: expected %02h, got %02h", want, m_tdata);
					fail_count++;
				end
			end
		end
		m_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: reset, directed script, then random phases across timing settings.
	initial begin
		script_row_t           row;
		logic [TIME_W-1:0]     frame;
		logic [TIME_W-1:0]     t;
		logic [TICKS_W-1:0]    period;
		logic [TICKS_W-1:0]    min_pulse;
		int                    phase;
		int                    n;
		int                    i;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_PERIOD_TICKS;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_LOAD;
		steady    <= 1'b0;

		period_reg    = PERIOD_TICKS_RESET;
		min_pulse_reg = MIN_PULSE_TICKS_RESET;
		for (i = 0; i < NUM_CH; i++) begin
			ch_on[i]   = 1'b0;
			win_lo2[i] = '0;
			win_hi2[i] = '0;
		end

		// Fields: is_cfg, mode, ch, act, t, known, mask, period, min_pulse.
		script = '{
			// Nothing is active after reset, at either end of the time range.
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd0, 1'b1, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, T_MAX, 1'b1, 8'h00, 16'd0, 16'd0},
			// Full duty fills the whole frame; end edge is exclusive.
			'{1'b0, MODE_LOAD, 3'd0, ACT_FULL, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd0, 1'b1, 8'h01, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd999, 1'b1, 8'h01, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd1000, 1'b1, 8'h00, 16'd0, 16'd0},
			// Half duty centered in a frame starting at 100.
			'{1'b0, MODE_LOAD, 3'd1, ACT_HALF, 32'd100, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd349, 1'b1, 8'h01, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd5, 18'h0, 32'd350, 1'b1, 8'h03, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd7, 18'h0, 32'd850, 1'b1, 8'h01, 16'd0, 16'd0},
			// Negative and overdriven activations clamp; latest frame start.
			'{1'b0, MODE_LOAD, 3'd2, ACT_MOST_NEG, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_LOAD, 3'd3, ACT_MOST_POS, T_MAX, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, T_MAX, 1'b1, 8'h08, 16'd0, 16'd0},
			// Truncation to zero on-time turns a channel off.
			'{1'b0, MODE_LOAD, 3'd0, ACT_LSB, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd0, 1'b1, 8'h00, 16'd0, 16'd0},
			// Deadband: a pulse below the minimum is dropped, one exactly at it is kept.
			'{1'b1, MODE_LOAD, 3'd0, 18'h0, 32'd0, 1'b0, 8'h00, 16'd1000, 16'd600},
			'{1'b0, MODE_LOAD, 3'd4, ACT_HALF, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd500, 1'b1, 8'h02, 16'd0, 16'd0},
			'{1'b0, MODE_LOAD, 3'd5, ACT_SIXTY, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd200, 1'b0, 8'h00, 16'd0, 16'd0},
			// Zero period: any load switches its channel off.
			'{1'b1, MODE_LOAD, 3'd0, 18'h0, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_LOAD, 3'd1, ACT_FULL, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd500, 1'b0, 8'h00, 16'd0, 16'd0},
			// Largest period with the minimum pulse equal to it.
			'{1'b1, MODE_LOAD, 3'd0, 18'h0, 32'd0, 1'b0, 8'h00, 16'hFFFF, 16'hFFFF},
			'{1'b0, MODE_LOAD, 3'd6, ACT_FULL, 32'd0, 1'b0, 8'h00, 16'd0, 16'd0},
			'{1'b0, MODE_QUERY, 3'd0, 18'h0, 32'd65534, 1'b0, 8'h00, 16'd0, 16'd0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			row = script[k];
			if (row.is_cfg) begin
				drain_results();
				set_timing(row.period, row.min_pulse);
			end else begin
				play_beat(row.mode, row.ch, row.act, row.t, row.known, row.mask);
			end
		end

		// Random phases, each with its own timing setting; the sender pauses before each change.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					period = PERIOD_TICKS_RESET;
					min_pulse = MIN_PULSE_TICKS_RESET;
				end
				1: begin
					period = 16'd1;
					min_pulse = 16'd0;
				end
				2: begin
					period = 16'hFFFF;
					min_pulse = 16'd0;
				end
				3: begin
					period = 16'd100;
					min_pulse = 16'd40;
				end
				4: begin
					period = 16'hFFFF;
					min_pulse = 16'hFFFF;
				end
				5: begin
					period = 16'd0;
					min_pulse = 16'd0;
				end
				6: begin
					period = 16'($urandom_range(2, 2000));
					min_pulse = 16'($urandom_range(0, period));
				end
				default: begin
					period = 16'd3;
					min_pulse = 16'd2;
				end
			endcase
			set_timing(period, min_pulse);
			steady <= (phase == STEADY_PHASE);
			frame = $urandom;

			for (n = 0; n < PHASE_BEATS; n++) begin
				// Now and then move on to the next frame.
				if ($urandom_range(0, 31) == 0)
					frame = frame + period_reg;
				if ($urandom_range(0, 9) < 4) begin
					t = ($urandom_range(0, 15) == 0) ? $urandom : frame;
					play_beat(MODE_LOAD, 3'($urandom_range(0, 7)), pick_activation(), t,
						1'b0, 8'h00);
				end else begin
					if ($urandom_range(0, 9) == 0)
						t = $urandom;
					else
						t = frame + $urandom_range(0, int'(period_reg) + 1);
					play_beat(MODE_QUERY, 3'($urandom_range(0, 7)), 18'($urandom), t,
						1'b0, 8'h00);
				end
			end
		end

		drain_results();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/cpwm_pkg.sv
src/centered_pwm_scheduler_deadband_top.sv
bench/tb_centered_pwm_scheduler_deadband_top.sv
